// ----- rtl/angwin_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angwin_pkg
// Shared types and constants of the angular window point filter: vector and
// lane records that travel down the angle cell chain, the arctangent table
// and the register index codes.
// ----------------------------------------------------------------------------
package angwin_pkg;

   localparam int COORD_W   = 32;  // Q16.16 coordinate width
   localparam int HW_W      = 17;  // half-window width
   localparam int VEC_W     = 35;  // rotation datapath, covers sqrt(2) * gain growth
   localparam int ANG_W     = 20;  // accumulated angle, |angle| < 2^18
   localparam int CMP_W     = 22;  // window bound width
   localparam int TABLE_LEN = 24;
   localparam int CSR_IDX_W = 2;

   // register index codes
   localparam logic [CSR_IDX_W-1:0] REG_RAY_X       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RAY_Y       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RAY_Z       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_WINDOW = 2'd3;

   localparam logic signed [COORD_W-1:0] RAY_Z_RESET       = 32'sd65536;
   localparam logic        [HW_W-1:0]    HALF_WINDOW_RESET = 17'd5719;

   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 20'sd102944;

   // round(atan(2^-i) * 65536)
   localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
      20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
      20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
      20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1,    20'sd0,
      20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0
   };

   // one vector under rotation; zero marks the origin case (angle 0)
   typedef struct packed {
      logic                     zero;
      logic signed [VEC_W-1:0]  x;
      logic signed [VEC_W-1:0]  y;
      logic signed [ANG_W-1:0]  ang;
   } vec_type;

   // everything one item carries down the chain
   typedef struct packed {
      vec_type                   pt_h;
      vec_type                   pt_v;
      vec_type                   ray_h;
      vec_type                   ray_v;
      logic        [HW_W-1:0]    half_window;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      cloud_end;
   } lane_type;

endpackage

// ----- rtl/angwin_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angwin channel interfaces
// Point request, filter response and register write channels, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface angwin_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [angwin_pkg::COORD_W-1:0]  point_x;
   logic signed [angwin_pkg::COORD_W-1:0]  point_y;
   logic signed [angwin_pkg::COORD_W-1:0]  point_z;
   logic                                   cloud_end;

   modport source (output valid, point_x, point_y, point_z, cloud_end, input ready);
   modport sink   (input valid, point_x, point_y, point_z, cloud_end, output ready);
endinterface

interface angwin_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   keep;
   logic signed [angwin_pkg::COORD_W-1:0]  kept_x;
   logic signed [angwin_pkg::COORD_W-1:0]  kept_y;
   logic signed [angwin_pkg::COORD_W-1:0]  kept_z;
   logic                                   last_point;

   modport source (output valid, keep, kept_x, kept_y, kept_z, last_point, input ready);
   modport sink   (input valid, keep, kept_x, kept_y, kept_z, last_point, output ready);
endinterface

interface angwin_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [angwin_pkg::CSR_IDX_W-1:0]       index;
   logic [angwin_pkg::COORD_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/angwin_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angwin_prep
// Entry cell: folds each of the four vectors into the right half plane
// (quarter-turn pre-rotation), flags the origin case and registers the lane.
// ----------------------------------------------------------------------------
module angwin_prep (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [angwin_pkg::COORD_W-1:0]  point_x,
   input  logic signed [angwin_pkg::COORD_W-1:0]  point_y,
   input  logic signed [angwin_pkg::COORD_W-1:0]  point_z,
   input  logic                                   cloud_end,
   input  logic signed [angwin_pkg::COORD_W-1:0]  ray_x,
   input  logic signed [angwin_pkg::COORD_W-1:0]  ray_y,
   input  logic signed [angwin_pkg::COORD_W-1:0]  ray_z,
   input  logic        [angwin_pkg::HW_W-1:0]     half_window,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output angwin_pkg::lane_type                   out_lane
);

   // build the start vector for atan2(n, d)
   function automatic angwin_pkg::vec_type fold(
      input logic signed [angwin_pkg::COORD_W-1:0] n,
      input logic signed [angwin_pkg::COORD_W-1:0] d
   );
      angwin_pkg::vec_type          v;
      logic signed [angwin_pkg::VEC_W-1:0] nw;
      logic signed [angwin_pkg::VEC_W-1:0] dw;
      nw     = angwin_pkg::VEC_W'(n);
      dw     = angwin_pkg::VEC_W'(d);
      v.zero = (n == '0) && (d == '0);
      if (d < 0) begin
         if (n >= 0) begin
            v.x   = nw;
            v.y   = -dw;
            v.ang = angwin_pkg::QUARTER_TURN;
         end else begin
            v.x   = -nw;
            v.y   = dw;
            v.ang = -angwin_pkg::QUARTER_TURN;
         end
      end else begin
         v.x   = dw;
         v.y   = nw;
         v.ang = '0;
      end
      return v;
   endfunction

   logic                 vld_ff;
   angwin_pkg::lane_type lane_ff;
   angwin_pkg::lane_type lane_in;

   // take a beat whenever the stage is empty or drains this cycle
   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_lane  = lane_ff;

   // assemble the lane
   always_comb begin
      lane_in.pt_h        = fold(point_x, point_z);
      lane_in.pt_v        = fold(point_y, point_z);
      lane_in.ray_h       = fold(ray_x, ray_z);
      lane_in.ray_v       = fold(ray_y, ray_z);
      lane_in.half_window = half_window;
      lane_in.point_x     = point_x;
      lane_in.point_y     = point_y;
      lane_in.point_z     = point_z;
      lane_in.cloud_end   = cloud_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         lane_ff <= lane_in;
      end
   end

endmodule

// ----- rtl/angwin_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angwin_cell
// One vectoring rotation step, applied to all four vectors of a lane, with
// a one-deep register and valid/ready toward both neighbors.
// ----------------------------------------------------------------------------
module angwin_cell #(
   parameter int unsigned SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  angwin_pkg::lane_type in_lane,
   output logic                 out_valid,
   input  logic                 out_ready,
   output angwin_pkg::lane_type out_lane
);

   // rotate toward the x axis by atan(2^-SHIFT)
   function automatic angwin_pkg::vec_type rotate(input angwin_pkg::vec_type v);
      angwin_pkg::vec_type r;
      r = v;
      if (!v.y[angwin_pkg::VEC_W-1]) begin
         r.x   = v.x + (v.y >>> SHIFT);
         r.y   = v.y - (v.x >>> SHIFT);
         r.ang = v.ang + angwin_pkg::ATAN_TAB[SHIFT];
      end else begin
         r.x   = v.x - (v.y >>> SHIFT);
         r.y   = v.y + (v.x >>> SHIFT);
         r.ang = v.ang - angwin_pkg::ATAN_TAB[SHIFT];
      end
      return r;
   endfunction

   logic                 vld_ff;
   angwin_pkg::lane_type lane_ff;
   angwin_pkg::lane_type lane_in;

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_lane  = lane_ff;

   // step all four vectors, pass the payload along
   always_comb begin
      lane_in       = in_lane;
      lane_in.pt_h  = rotate(in_lane.pt_h);
      lane_in.pt_v  = rotate(in_lane.pt_v);
      lane_in.ray_h = rotate(in_lane.ray_h);
      lane_in.ray_v = rotate(in_lane.ray_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         lane_ff <= lane_in;
      end
   end

endmodule

// ----- rtl/angular_window_point_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angular_window_point_filter_unit
// Keeps a point when its horizontal and vertical atan2 angles both lie
// within +/- half_window of the angles of the configured ray direction.
//
//   channel  | dir | beat contents
//   ---------+-----+-------------------------------------------------
//   req_bus  | in  | point_x, point_y, point_z (Q16.16), cloud_end
//   rsp_bus  | out | keep, kept_x, kept_y, kept_z, last_point
//   csr_bus  | in  | index (ray_x, ray_y, ray_z, half_window), data
//
// One point per cycle sustained while rsp_bus is ready; the path is one
// pre-rotation cell, ANGLE_STAGES rotation cells, one window compare register.
// Every cell holds its beat under backpressure and refills its own bubble,
// so a stalled response leaves the chain accepting until all cells are full.
// Reset clears cell valid bits and loads the register defaults; register
// writes are always ready.
// ----------------------------------------------------------------------------
module angular_window_point_filter_unit #(
   parameter int ANGLE_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   angwin_req_if.sink   req_bus,
   angwin_rsp_if.source rsp_bus,
   angwin_csr_if.sink   csr_bus
);

   // ray direction and window registers
   logic signed [angwin_pkg::COORD_W-1:0] ray_x_ff;
   logic signed [angwin_pkg::COORD_W-1:0] ray_y_ff;
   logic signed [angwin_pkg::COORD_W-1:0] ray_z_ff;
   logic        [angwin_pkg::HW_W-1:0]    half_window_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_x_ff       <= '0;
         ray_y_ff       <= '0;
         ray_z_ff       <= angwin_pkg::RAY_Z_RESET;
         half_window_ff <= angwin_pkg::HALF_WINDOW_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            angwin_pkg::REG_RAY_X:       ray_x_ff <= csr_bus.data;
            angwin_pkg::REG_RAY_Y:       ray_y_ff <= csr_bus.data;
            angwin_pkg::REG_RAY_Z:       ray_z_ff <= csr_bus.data;
            angwin_pkg::REG_HALF_WINDOW: half_window_ff <= csr_bus.data[angwin_pkg::HW_W-1:0];
            default: ;
         endcase
      end
   end

   // chain links: link 0 is the prep output, link ANGLE_STAGES the last cell
   logic                 link_valid [ANGLE_STAGES+1];
   logic                 link_ready [ANGLE_STAGES+1];
   angwin_pkg::lane_type link_lane  [ANGLE_STAGES+1];

   angwin_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .point_x     (req_bus.point_x),
      .point_y     (req_bus.point_y),
      .point_z     (req_bus.point_z),
      .cloud_end   (req_bus.cloud_end),
      .ray_x       (ray_x_ff),
      .ray_y       (ray_y_ff),
      .ray_z       (ray_z_ff),
      .half_window (half_window_ff),
      .out_valid   (link_valid[0]),
      .out_ready   (link_ready[0]),
      .out_lane    (link_lane[0])
   );

   for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cell
      angwin_cell #(
         .SHIFT (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_lane   (link_lane[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_lane  (link_lane[g+1])
      );
   end

   // window compare on the finished angles
   angwin_pkg::lane_type                 tail;
   logic signed [angwin_pkg::CMP_W-1:0] hw_ext;
   logic signed [angwin_pkg::CMP_W-1:0] pt_h_a, pt_v_a, ray_h_a, ray_v_a;
   logic                                 keep_in;

   assign tail   = link_lane[ANGLE_STAGES];
   assign hw_ext = $signed({{(angwin_pkg::CMP_W-angwin_pkg::HW_W){1'b0}}, tail.half_window});

   always_comb begin
      pt_h_a  = tail.pt_h.zero  ? '0 : angwin_pkg::CMP_W'(tail.pt_h.ang);
      pt_v_a  = tail.pt_v.zero  ? '0 : angwin_pkg::CMP_W'(tail.pt_v.ang);
      ray_h_a = tail.ray_h.zero ? '0 : angwin_pkg::CMP_W'(tail.ray_h.ang);
      ray_v_a = tail.ray_v.zero ? '0 : angwin_pkg::CMP_W'(tail.ray_v.ang);
      keep_in = (pt_h_a >= ray_h_a - hw_ext) && (pt_h_a <= ray_h_a + hw_ext)
             && (pt_v_a >= ray_v_a - hw_ext) && (pt_v_a <= ray_v_a + hw_ext);
   end

   // response register
   logic                                  out_vld_ff;
   logic                                  keep_ff;
   logic signed [angwin_pkg::COORD_W-1:0] kept_x_ff;
   logic signed [angwin_pkg::COORD_W-1:0] kept_y_ff;
   logic signed [angwin_pkg::COORD_W-1:0] kept_z_ff;
   logic                                  last_ff;

   assign link_ready[ANGLE_STAGES] = !out_vld_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (link_ready[ANGLE_STAGES]) begin
         out_vld_ff <= link_valid[ANGLE_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (link_valid[ANGLE_STAGES] && link_ready[ANGLE_STAGES]) begin
         keep_ff   <= keep_in;
         kept_x_ff <= tail.point_x;
         kept_y_ff <= tail.point_y;
         kept_z_ff <= tail.point_z;
         last_ff   <= tail.cloud_end;
      end
   end

   assign rsp_bus.valid      = out_vld_ff;
   assign rsp_bus.keep       = keep_ff;
   assign rsp_bus.kept_x     = kept_x_ff;
   assign rsp_bus.kept_y     = kept_y_ff;
   assign rsp_bus.kept_z     = kept_z_ff;
   assign rsp_bus.last_point = last_ff;

endmodule
